// ===== src/dpts_pkg.sv =====
// Shared types and codes for the depth-priority task stack.
`default_nettype none

package dpts_pkg;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  localparam logic [1:0] ST_PUSHED = 2'd0;
  localparam logic [1:0] ST_POPPED = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned DEPTH_W  = 16;

  typedef struct packed {
    logic wr_en;
    logic wr_val;
    logic scan_start;
  } lvl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic rd_bit;
  } lvl_stat_t;

endpackage

`default_nettype wire

// ===== src/dpts_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none

module dpts_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// ===== src/dpts_lvl.sv =====
// Level occupancy bits and the downward scanner for the next non-empty level.
`default_nettype none

module dpts_lvl #(
  parameter int unsigned LEVELS = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire dpts_pkg::lvl_cmd_t        cmd_i,
  input  wire logic [$clog2(LEVELS)-1:0] wr_idx_i,
  input  wire logic [$clog2(LEVELS)-1:0] rd_idx_i,
  input  wire logic [$clog2(LEVELS)-1:0] scan_from_i,
  output dpts_pkg::lvl_stat_t            stat_o,
  output logic      [$clog2(LEVELS)-1:0] found_o
);

  localparam int unsigned LW = $clog2(LEVELS);

  logic [LEVELS-1:0] bits_q, bits_d;
  logic [LW-1:0]     lv_q, lv_d;
  logic              busy_q, busy_d;
  logic              hit;

  assign hit = bits_q[lv_q] || (lv_q == '0);

  always_comb begin
    bits_d = bits_q;
    lv_d   = lv_q;
    busy_d = busy_q;
    if (cmd_i.wr_en) begin
      bits_d[wr_idx_i] = cmd_i.wr_val;
    end
    if (cmd_i.scan_start) begin
      busy_d = 1'b1;
      lv_d   = (scan_from_i == '0) ? '0 : scan_from_i - LW'(1);
    end else if (busy_q) begin
      if (hit) begin
        busy_d = 1'b0;
      end else begin
        lv_d = lv_q - LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
      lv_q   <= '0;
      busy_q <= 1'b0;
    end else begin
      bits_q <= bits_d;
      lv_q   <= lv_d;
      busy_q <= busy_d;
    end
  end

  assign stat_o.scan_done = busy_q && hit;
  assign stat_o.rd_bit    = bits_q[rd_idx_i];
  assign found_o          = lv_q;

endmodule

`default_nettype wire

// ===== src/depth_priority_task_stack.sv =====
// Top level of the depth-priority task stack: sequencer, head and link memories, free pool.
// Requests enter on start/busy: a request is taken at a clock edge where start is
// high and busy is low. A push stores task_handle_i at level min(task_depth_i, TOP_LEVEL);
// a pop returns the most recently pushed handle of the highest occupied level.
// Each request yields one result, shown on out_handle_o and status_o for one cycle
// while done_o is high; the receiver cannot hold results back.
// A push first reads the free-pool and level-head memories, then writes the links.
// A pop reads the head, then reads the entry, then updates the head.
// When a pop empties its level, the level scanner steps down one level per cycle
// and busy stays high until it finds an occupied level or reaches level zero.
// A request that meets a full pool or an empty store is answered the cycle after it is taken.
// The result strobe follows the last cycle of a push or the head update of a pop.
// Busy is already low while it is shown, unless that pop has started a level scan.
// Reset clears the level occupancy bits, empties the store and refills the pool;
// no clearing pass is needed, as unused pool slots are tracked by a low-water mark.
`default_nettype none

module depth_priority_task_stack #(
  parameter int unsigned TOP_LEVEL    = 63,
  parameter int unsigned POOL_ENTRIES = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        req_type_i,
  input  wire logic [15:0] task_depth_i,
  input  wire logic [15:0] task_handle_i,
  output logic             done_o,
  output logic [15:0]      out_handle_o,
  output logic [1:0]       status_o
);

  localparam int unsigned LEVELS = TOP_LEVEL + 1;
  localparam int unsigned LW     = $clog2(LEVELS);
  localparam int unsigned IW     = $clog2(POOL_ENTRIES);
  localparam int unsigned CW     = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned HW     = dpts_pkg::HANDLE_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PUSH1 = 3'd1;
  localparam logic [2:0] S_POP1  = 3'd2;
  localparam logic [2:0] S_POP2  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [LW-1:0] depth_q, depth_d;
  logic [HW-1:0] handle_q, handle_d;
  logic [IW-1:0] slot_q, slot_d;
  logic          fresh_q, fresh_d;
  logic [CW-1:0] fc_q, fc_d;
  logic [CW-1:0] lw_q, lw_d;
  logic [LW-1:0] top_q, top_d;
  logic          done_q, done_d;
  logic [HW-1:0] out_handle_q, out_handle_d;
  logic [1:0]    status_q, status_d;

  logic          accept;
  logic [LW-1:0] depth_clamp;
  logic [CW-1:0] fc_m1;
  logic [IW-1:0] push_slot;

  logic          head_we;
  logic [LW-1:0] head_addr;
  logic [IW-1:0] head_wdata, head_rdata;

  logic          ent_we;
  logic [IW-1:0] ent_addr;
  logic [HW-1:0] hnd_rdata;
  logic [IW:0]   nxt_wdata, nxt_rdata;

  logic          free_we;
  logic [IW-1:0] free_addr, free_rdata;

  dpts_pkg::lvl_cmd_t  lvl_cmd;
  dpts_pkg::lvl_stat_t lvl_stat;
  logic [LW-1:0]       lvl_wr_idx, lvl_rd_idx, lvl_found;

  assign accept      = start && !busy;
  assign depth_clamp = (task_depth_i > dpts_pkg::DEPTH_W'(TOP_LEVEL)) ? LW'(TOP_LEVEL)
                                                                     : task_depth_i[LW-1:0];
  assign fc_m1       = fc_q - CW'(1);
  assign push_slot   = fresh_q ? fc_q[IW-1:0] : free_rdata;

  always_comb begin
    state_d      = state_q;
    depth_d      = depth_q;
    handle_d     = handle_q;
    slot_d       = slot_q;
    fresh_d      = fresh_q;
    fc_d         = fc_q;
    lw_d         = lw_q;
    top_d        = top_q;
    done_d       = 1'b0;
    out_handle_d = '0;
    status_d     = status_q;

    head_we      = 1'b0;
    head_addr    = top_q;
    head_wdata   = nxt_rdata[IW-1:0];
    ent_we       = 1'b0;
    ent_addr     = head_rdata;
    nxt_wdata    = {lvl_stat.rd_bit, head_rdata};
    free_we      = 1'b0;
    free_addr    = fc_q[IW-1:0];
    lvl_cmd      = '0;
    lvl_wr_idx   = top_q;
    lvl_rd_idx   = top_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          depth_d  = depth_clamp;
          handle_d = task_handle_i;
          if (req_type_i == dpts_pkg::REQ_PUSH) begin
            if (fc_q == '0) begin
              done_d   = 1'b1;
              status_d = dpts_pkg::ST_FULL;
            end else begin
              head_addr = depth_clamp;
              free_addr = fc_m1[IW-1:0];
              fresh_d   = fc_m1 < lw_q;
              if (fc_m1 < lw_q) begin
                lw_d = fc_m1;
              end
              fc_d    = fc_m1;
              state_d = S_PUSH1;
            end
          end else begin
            if (!lvl_stat.rd_bit) begin
              done_d   = 1'b1;
              status_d = dpts_pkg::ST_EMPTY;
            end else begin
              state_d = S_POP1;
            end
          end
        end
      end
      S_PUSH1: begin
        lvl_rd_idx         = depth_q;
        head_addr          = depth_q;
        head_we            = 1'b1;
        head_wdata         = push_slot;
        ent_addr           = push_slot;
        ent_we             = 1'b1;
        lvl_wr_idx         = depth_q;
        lvl_cmd.wr_en      = 1'b1;
        lvl_cmd.wr_val     = 1'b1;
        if (depth_q > top_q) begin
          top_d = depth_q;
        end
        done_d   = 1'b1;
        status_d = dpts_pkg::ST_PUSHED;
        state_d  = S_IDLE;
      end
      S_POP1: begin
        slot_d  = head_rdata;
        state_d = S_POP2;
      end
      S_POP2: begin
        head_we        = 1'b1;
        lvl_cmd.wr_en  = 1'b1;
        lvl_cmd.wr_val = nxt_rdata[IW];
        free_addr      = fc_q[IW-1:0];
        if (fc_q < CW'(POOL_ENTRIES)) begin
          free_we = 1'b1;
          fc_d    = fc_q + CW'(1);
        end
        done_d       = 1'b1;
        out_handle_d = hnd_rdata;
        status_d     = dpts_pkg::ST_POPPED;
        if (nxt_rdata[IW]) begin
          state_d = S_IDLE;
        end else begin
          lvl_cmd.scan_start = 1'b1;
          state_d            = S_SCAN;
        end
      end
      S_SCAN: begin
        if (lvl_stat.scan_done) begin
          top_d   = lvl_found;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fc_q     <= CW'(POOL_ENTRIES);
      lw_q     <= CW'(POOL_ENTRIES);
      top_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      fc_q     <= fc_d;
      lw_q     <= lw_d;
      top_q    <= top_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    depth_q      <= depth_d;
    handle_q     <= handle_d;
    slot_q       <= slot_d;
    fresh_q      <= fresh_d;
    out_handle_q <= out_handle_d;
    status_q     <= status_d;
  end

  dpts_ram #(
    .WIDTH (IW),
    .DEPTH (LEVELS)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .addr_i  (head_addr),
    .wdata_i (head_wdata),
    .rdata_o (head_rdata)
  );

  dpts_ram #(
    .WIDTH (HW),
    .DEPTH (POOL_ENTRIES)
  ) u_handle_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .addr_i  (ent_addr),
    .wdata_i (handle_q),
    .rdata_o (hnd_rdata)
  );

  dpts_ram #(
    .WIDTH (IW + 1),
    .DEPTH (POOL_ENTRIES)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .addr_i  (ent_addr),
    .wdata_i (nxt_wdata),
    .rdata_o (nxt_rdata)
  );

  dpts_ram #(
    .WIDTH (IW),
    .DEPTH (POOL_ENTRIES)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (free_we),
    .addr_i  (free_addr),
    .wdata_i (slot_q),
    .rdata_o (free_rdata)
  );

  dpts_lvl #(
    .LEVELS (LEVELS)
  ) u_lvl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (lvl_cmd),
    .wr_idx_i    (lvl_wr_idx),
    .rd_idx_i    (lvl_rd_idx),
    .scan_from_i (top_q),
    .stat_o      (lvl_stat),
    .found_o     (lvl_found)
  );

  assign busy         = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign out_handle_o = out_handle_q;
  assign status_o     = status_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= CW'(POOL_ENTRIES))
    else $error("Free count has run past the pool size.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && top_q != '0) |-> lvl_stat.rd_bit)
    else $error("The highest-level mark points at an empty level.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP2) |=> (done_o && status_o == dpts_pkg::ST_POPPED))
    else $error("A pop request finished without a popped result.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i == dpts_pkg::REQ_POP && !lvl_stat.rd_bit)
      |=> (done_o && status_o == dpts_pkg::ST_EMPTY && out_handle_o == '0))
    else $error("A pop request on an empty store was not answered as empty.");

endmodule

`default_nettype wire

// ===== dv/tb_depth_priority_task_stack.sv =====
// Self-checking testbench for the depth-priority task stack: directed, pool-fill and random requests.
`timescale 1ns / 100ps

module tb_depth_priority_task_stack;

  localparam int unsigned TOP_LEVEL    = 63;
  localparam int unsigned POOL_ENTRIES = 1024;
  localparam int unsigned RANDOM_REQS  = 650;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [dpts_pkg::HANDLE_W-1:0] handle;
    logic [1:0]                    status;
  } stack_result_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          start         = 1'b0;
  logic                          req_type_i    = dpts_pkg::REQ_PUSH;
  logic [dpts_pkg::DEPTH_W-1:0]  task_depth_i  = '0;
  logic [dpts_pkg::HANDLE_W-1:0] task_handle_i = '0;
  logic                          busy;
  logic                          done_o;
  logic [15:0]                   out_handle_o;
  logic [1:0]                    status_o;

  int unsigned    shadow_head     [0:TOP_LEVEL];
  bit             shadow_occupied [0:TOP_LEVEL];
  logic [15:0]    shadow_handle   [0:POOL_ENTRIES-1];
  int unsigned    shadow_link     [0:POOL_ENTRIES-1];
  bit             shadow_link_ok  [0:POOL_ENTRIES-1];
  int unsigned    shadow_free     [0:POOL_ENTRIES-1];
  int unsigned    shadow_free_cnt;
  int unsigned    shadow_top;

  stack_result_t  expected_results [$];
  int unsigned    cycle_count;
  int unsigned    failures;
  int unsigned    results_checked;
  int unsigned    burst_left;
  bit             sender_gaps;
  int unsigned    pushes_stored, pushes_refused, pops_served, pops_refused;

  depth_priority_task_stack #(
    .TOP_LEVEL   (TOP_LEVEL),
    .POOL_ENTRIES(POOL_ENTRIES)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_type_i   (req_type_i),
    .task_depth_i (task_depth_i),
    .task_handle_i(task_handle_i),
    .done_o       (done_o),
    .out_handle_o (out_handle_o),
    .status_o     (status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic stack_result_t predict_stack_request(logic rtype, logic [15:0] depth,
                                                          logic [15:0] handle);
    stack_result_t res;
    int unsigned   lvl;
    int unsigned   slot;
    res.handle = '0;
    if (rtype == dpts_pkg::REQ_PUSH) begin
      if (shadow_free_cnt == 0) begin
        res.status = dpts_pkg::ST_FULL;
        pushes_refused++;
        return res;
      end
      lvl = (depth > TOP_LEVEL) ? TOP_LEVEL : depth;
      shadow_free_cnt--;
      slot = shadow_free[shadow_free_cnt];
      shadow_handle[slot]   = handle;
      shadow_link[slot]     = shadow_head[lvl];
      shadow_link_ok[slot]  = shadow_occupied[lvl];
      shadow_head[lvl]      = slot;
      shadow_occupied[lvl]  = 1'b1;
      if (lvl > shadow_top) shadow_top = lvl;
      res.status = dpts_pkg::ST_PUSHED;
      pushes_stored++;
    end else begin
      if (!shadow_occupied[shadow_top]) begin
        res.status = dpts_pkg::ST_EMPTY;
        pops_refused++;
        return res;
      end
      slot = shadow_head[shadow_top];
      res.handle = shadow_handle[slot];
      res.status = dpts_pkg::ST_POPPED;
      shadow_head[shadow_top]     = shadow_link[slot];
      shadow_occupied[shadow_top] = shadow_link_ok[slot];
      shadow_free[shadow_free_cnt] = slot;
      shadow_free_cnt++;
      while (shadow_top > 0 && !shadow_occupied[shadow_top]) shadow_top--;
      pops_served++;
    end
    return res;
  endfunction

  task automatic note_failure(string what);
    failures++;
    if (failures <= 10) $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  always @(posedge clk_i) begin
    stack_result_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        note_failure($sformatf("result with no request pending: handle %h status %0d",
                               out_handle_o, status_o));
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_handle_o !== want.handle)
          note_failure($sformatf("out_handle expected %h actual %h", want.handle,
                                 out_handle_o));
        if (status_o !== want.status)
          note_failure($sformatf("status expected %0d actual %0d", want.status, status_o));
      end
    end
  end

  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_request(logic rtype, logic [15:0] depth, logic [15:0] handle);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (sender_gaps && $urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
    end
    burst_left--;
    @(negedge clk_i);
    start         <= 1'b1;
    req_type_i    <= rtype;
    task_depth_i  <= depth;
    task_handle_i <= handle;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_results.push_back(predict_stack_request(rtype, depth, handle));
  endtask

  task automatic send_pop();
    send_request(dpts_pkg::REQ_POP, 16'($urandom), 16'($urandom));
  endtask

  task automatic test_empty_store();
    send_pop();
    send_request(dpts_pkg::REQ_PUSH, 16'h0000, 16'h0000);
    send_pop();
    send_pop();
  endtask

  task automatic test_depth_order();
    send_request(dpts_pkg::REQ_PUSH, 16'hFFFF, 16'hFFFF);
    send_request(dpts_pkg::REQ_PUSH, 16'd63,   16'h1234);
    send_request(dpts_pkg::REQ_PUSH, 16'd64,   16'h8000);
    send_request(dpts_pkg::REQ_PUSH, 16'd0,    16'h0001);
    send_request(dpts_pkg::REQ_PUSH, 16'd62,   16'h7FFF);
    send_request(dpts_pkg::REQ_PUSH, 16'h8000, 16'h5555);
    repeat (7) send_pop();
  endtask

  task automatic test_pool_full();
    sender_gaps = 1'b0;
    while (shadow_free_cnt > 0) begin
      if (shadow_free_cnt == POOL_ENTRIES / 2) sender_gaps = 1'b1;
      if ($urandom_range(0, 4) == 0)
        send_request(dpts_pkg::REQ_PUSH, 16'($urandom), 16'($urandom));
      else
        send_request(dpts_pkg::REQ_PUSH, 16'($urandom_range(0, TOP_LEVEL + 2)),
                     16'($urandom));
    end
    repeat (3) send_request(dpts_pkg::REQ_PUSH, 16'($urandom), 16'($urandom));
    wait_drained();
    while (shadow_free_cnt < POOL_ENTRIES) send_pop();
    repeat (2) send_pop();
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned phase_len;
    int unsigned push_weight;
    logic [15:0] depth;
    sent = 0;
    while (sent < RANDOM_REQS) begin
      phase_len   = $urandom_range(20, 60);
      push_weight = $urandom_range(2, 8);
      sender_gaps = ($urandom_range(0, 2) != 0);
      repeat (phase_len) begin
        if ($urandom_range(0, 9) < push_weight) begin
          case ($urandom_range(0, 9))
            0, 1:    depth = 16'($urandom);
            2, 3, 4: depth = 16'($urandom_range(0, 3));
            default: depth = 16'($urandom_range(0, TOP_LEVEL + 2));
          endcase
          send_request(dpts_pkg::REQ_PUSH, depth, 16'($urandom));
        end else begin
          send_pop();
        end
        sent++;
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
    sender_gaps = 1'b1;
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("Timed out after %0d cycles with %0d results pending", cycle_count,
             expected_results.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    cycle_count = 0;
    failures = 0;
    results_checked = 0;
    burst_left = 0;
    sender_gaps = 1'b1;
    pushes_stored = 0;
    pushes_refused = 0;
    pops_served = 0;
    pops_refused = 0;
    for (int unsigned i = 0; i < POOL_ENTRIES; i++) begin
      shadow_free[i]    = i;
      shadow_link[i]    = 0;
      shadow_link_ok[i] = 1'b0;
      shadow_handle[i]  = '0;
    end
    for (int unsigned i = 0; i <= TOP_LEVEL; i++) begin
      shadow_head[i]     = 0;
      shadow_occupied[i] = 1'b0;
    end
    shadow_free_cnt = POOL_ENTRIES;
    shadow_top = 0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_store();
    test_depth_order();
    test_pool_full();
    test_random_traffic();

    wait_drained();
    idle_cycles(TOP_LEVEL + 8);

    $display("Checked %0d results: %0d pushes stored, %0d refused on a full pool,",
             results_checked, pushes_stored, pushes_refused);
    $display("%0d pops served, %0d refused on an empty store; %0d mismatches.",
             pops_served, pops_refused, failures);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
